FILE: src/text_console_writer_assert.svh
// Assertion macros shared by the checker files.
// Each macro expects clk and rst_n in scope.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console writer check failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console writer check failed (next cycle)");

`endif

FILE: src/tcw_pkg.sv
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 8;

  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;
  localparam int ADDR_W   = 11;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int ACTION_W = 2;

  // Stream packing
  localparam int IN_DATA_W    = 24;
  localparam int IN_CHAR_LSB  = 0;
  localparam int IN_ADDR_LSB  = 8;
  localparam int OUT_DATA_W   = 32;
  localparam int OUT_CUR_LSB  = 0;
  localparam int OUT_CELL_LSB = 11;
  localparam int OUT_SCR_BIT  = 27;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_ATTR = 1'b0;

  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, CH_SPACE};

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  // Status of one put request as seen by the sequencer
  typedef struct packed {
    logic printable;
    logic scroll;
  } put_info_t;

endpackage

FILE: src/tcw_mem.sv
`timescale 1ns / 1ps
module tcw_mem #(
  parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [tcw_pkg::CELL_W-1:0]  rd_data
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/tcw_cursor.sv
`timescale 1ns / 1ps
module tcw_cursor #(
  parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS      = tcw_pkg::DEF_ROWS,
  parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH,
  parameter int PW        = $clog2(COLUMNS * ROWS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       put_en,
  input  logic                       home_en,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  output tcw_pkg::put_info_t         info,
  output logic [PW-1:0]              pos
);
  import tcw_pkg::*;

  localparam int CW  = $clog2(COLUMNS);
  localparam int RW  = $clog2(ROWS);
  localparam int TPW = $clog2(TAB_WIDTH);
  localparam int NW  = $clog2(COLUMNS + TAB_WIDTH);
  localparam int RNW = $clog2(ROWS + 1);

  logic [CW-1:0]  col_r,   col_nxt;
  logic [RW-1:0]  row_r,   row_nxt;
  logic [TPW-1:0] phase_r, phase_nxt;   // column modulo tab width

  logic [NW-1:0]  col_s;
  logic [RNW-1:0] row_s;
  logic [TPW-1:0] phase_s;
  logic           printable;
  logic           scroll;

  assign printable = !char_code[7] && (char_code[6:5] != 2'b00);

  always_comb begin
    col_s   = NW'(col_r);
    row_s   = RNW'(row_r);
    phase_s = phase_r;
    case (char_code)
      CH_BS: begin
        if (col_r != '0) begin
          col_s   = NW'(col_r) - NW'(1);
          phase_s = (phase_r == '0) ? TPW'(TAB_WIDTH - 1) : phase_r - TPW'(1);
        end
      end
      CH_TAB: begin
        col_s   = NW'(col_r) + NW'(TAB_WIDTH) - NW'(phase_r);
        phase_s = '0;
      end
      CH_CR: begin
        col_s   = '0;
        phase_s = '0;
      end
      CH_LF: begin
        col_s   = '0;
        row_s   = RNW'(row_r) + RNW'(1);
        phase_s = '0;
      end
      default: begin
        if (printable) begin
          col_s   = NW'(col_r) + NW'(1);
          phase_s = (phase_r == TPW'(TAB_WIDTH - 1)) ? '0 : phase_r + TPW'(1);
        end
      end
    endcase
    // wrap at the right edge
    if (col_s >= NW'(COLUMNS)) begin
      col_s   = '0;
      row_s   = row_s + RNW'(1);
      phase_s = '0;
    end
  end

  assign scroll = (row_s >= RNW'(ROWS));
  assign info   = '{printable: printable, scroll: scroll};

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    phase_nxt = phase_r;
    if (home_en) begin
      col_nxt   = '0;
      row_nxt   = '0;
      phase_nxt = '0;
    end else if (put_en) begin
      col_nxt   = CW'(col_s);
      phase_nxt = phase_s;
      row_nxt   = scroll ? RW'(ROWS - 1) : RW'(row_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign pos = PW'(row_r) * PW'(COLUMNS) + PW'(col_r);

endmodule

FILE: src/text_console_writer.sv
`timescale 1ns / 1ps
// Put, read and no-op requests go from IDLE to DONE, then load the result register;
// a put that scrolls first passes through SCROLL for the row move and blank fill,
// and a clear first passes through CLEAR to blank the store; DONE waits on a stalled
// result. One request at a time: in_tready is low until the result loads.
// Reset (rst_n low, synchronous) homes the cursor, sets the attribute to 0x0F and then
// runs a pass blanking every cell of the store; no request is taken meanwhile.
module text_console_writer #(
  parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS      = tcw_pkg::DEF_ROWS,
  parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0]   in_tdata,   // char_code[7:0], cell_address[18:8]
  input  logic [tcw_pkg::ACTION_W-1:0]    in_tuser,   // action[1:0]
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]  out_tdata,  // cursor_position[10:0],
                                                      // cell_data[26:11], scrolled[27]
  // configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int MOVE  = CELLS - COLUMNS;     // cells shifted up by a scroll
  localparam int AW    = $clog2(CELLS);
  localparam int KW    = $clog2(CELLS + 1);

  // ---------------------------------------------------------------------------
  // Configuration: one attribute register, byte address 0
  // ---------------------------------------------------------------------------
  logic [ATTR_W-1:0] attr_r, attr_nxt;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    attr_nxt = attr_r;
    if (cfg_wr && (cfg_paddr[CFG_ADDR_W-1] == REG_ATTR)) begin
      attr_nxt = cfg_pwdata[ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_ATTR)
                    ? CFG_DATA_W'(attr_r) : '0;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic [ACTION_W-1:0] in_action;
  logic [CHAR_W-1:0]   in_char;
  logic [ADDR_W-1:0]   in_addr;
  logic                in_acc;
  logic                in_rd_ok;

  assign in_action = in_tuser;
  assign in_char   = in_tdata[IN_CHAR_LSB +: CHAR_W];
  assign in_addr   = in_tdata[IN_ADDR_LSB +: ADDR_W];
  assign in_acc    = in_tvalid && in_tready;
  // reads past the last cell return zero
  assign in_rd_ok  = (in_action == ACT_READ) && (32'(in_addr) < 32'(CELLS));

  // ---------------------------------------------------------------------------
  // Cursor tracker
  // ---------------------------------------------------------------------------
  put_info_t      put_info;
  logic [AW-1:0]  cur_pos;
  logic           put_en;
  logic           home_en;

  assign put_en  = in_acc && (in_action == ACT_PUT);
  assign home_en = in_acc && (in_action == ACT_CLEAR);

  tcw_cursor #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH),
    .PW        (AW)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .put_en    (put_en),
    .home_en   (home_en),
    .char_code (in_char),
    .info      (put_info),
    .pos       (cur_pos)
  );

  // ---------------------------------------------------------------------------
  // Cell store
  // ---------------------------------------------------------------------------
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [CELL_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [CELL_W-1:0] mem_rd_data;

  tcw_mem #(
    .DEPTH   (CELLS),
    .AW      (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: one sweep counter and adder serve init, clear and scroll
  // ---------------------------------------------------------------------------
  state_t          state_r, state_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic [KW-1:0]   k_src;          // sweep counter advanced one row
  logic [CELL_W-1:0] blank;
  logic            out_free;

  logic            rd_ok_r, rd_ok_nxt;
  logic            scr_r,   scr_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  assign out_free = !out_valid_r || out_tready;
  assign k_src    = k_r + KW'(COLUMNS);
  assign blank    = (state_r == ST_INIT) ? RESET_BLANK : {attr_r, CH_SPACE};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (k_r == KW'(CELLS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_action == ACT_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if ((in_action == ACT_PUT) && put_info.scroll) begin
            state_nxt = ST_SCROLL;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCROLL: begin
        if (k_r == KW'(CELLS)) state_nxt = ST_DONE;
      end
      ST_CLEAR: begin
        if (k_r == KW'(CELLS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // store port control
  always_comb begin
    in_tready   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = AW'(k_r);
    mem_wr_data = blank;
    mem_rd_en   = 1'b0;
    mem_rd_addr = AW'(k_src);
    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        mem_wr_en = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        // write the character at the old cursor, start a cell read
        mem_wr_en   = put_en && put_info.printable;
        mem_wr_addr = cur_pos;
        mem_wr_data = {attr_r, in_char};
        mem_rd_en   = in_acc && in_rd_ok;
        mem_rd_addr = AW'(in_addr);
      end
      ST_SCROLL: begin
        // read one row ahead of the sweep count, write one cell behind it
        mem_rd_en   = (k_r < KW'(MOVE));
        mem_wr_en   = (k_r != '0);
        mem_wr_addr = AW'(k_r - KW'(1));
        mem_wr_data = (k_r <= KW'(MOVE)) ? mem_rd_data : blank;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // advance the sweep counter, restart it on every state change
  assign k_nxt = (state_nxt != state_r) ? '0 : k_r + KW'(1);

  always_comb begin
    rd_ok_nxt = rd_ok_r;
    scr_nxt   = scr_r;
    if (in_acc) begin
      rd_ok_nxt = in_rd_ok;
      scr_nxt   = put_en && put_info.scroll;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r <= rd_ok_nxt;
    scr_r   <= scr_nxt;
  end

  // ---------------------------------------------------------------------------
  // Result register: the next request may enter while this one waits
  // ---------------------------------------------------------------------------
  logic load_out;

  assign load_out = (state_r == ST_DONE) && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // pack the result fields, zero the pad bits
  always_comb begin
    out_data_nxt = out_data_r;
    if (load_out) begin
      out_data_nxt = '0;
      out_data_nxt[OUT_CUR_LSB +: CURSOR_W] = CURSOR_W'(cur_pos);
      out_data_nxt[OUT_CELL_LSB +: CELL_W]  = rd_ok_r ? mem_rd_data : '0;
      out_data_nxt[OUT_SCR_BIT]             = scr_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: src/tcw_checker.sv
`timescale 1ns / 1ps
`include "text_console_writer_assert.svh"
module tcw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tcw_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import tcw_pkg::*;

  // a stalled result holds
  `TCW_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // one request at a time: never ready right after taking one
  `TCW_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // only a put scrolls, and a put carries no cell word
  `TCW_ASSERT_SAME(a_scroll_no_data, out_tvalid && out_tdata[OUT_SCR_BIT],
                   out_tdata[OUT_CELL_LSB +: CELL_W] == '0)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tcw_pkg::*;

  // Screen geometry follows the block's defaults.
  localparam int COLUMNS    = DEF_COLUMNS;
  localparam int ROWS       = DEF_ROWS;
  localparam int TAB_WIDTH  = DEF_TAB_WIDTH;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // Action code with no function in the block; it must still report the cursor.
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  // Character codes used by the directed requests.
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ESC       = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_DEL       = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_HIGH_LOW  = 8'h80;
  localparam logic [CHAR_W-1:0] CH_HIGH_TOP  = 8'hFF;
  localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_X   = 8'h78;

  // Byte address of the attribute register on the config port.
  localparam logic [CFG_ADDR_W-1:0] ATTR_ADDR = CFG_ADDR_W'(4 * int'(REG_ATTR));

  localparam logic [ATTR_W-1:0] ATTR_ALL_ZERO = 8'h00;
  localparam logic [ATTR_W-1:0] ATTR_ALL_ONE  = 8'hFF;

  // A scroll or clear walks the whole store, and the long receiver hold-off
  // adds to the wait. Leave plenty of margin.
  localparam int IDLE_LIMIT      = 10000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_CHUNKS   = 5;
  localparam int CHUNK_REQUESTS  = 90;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CELL_W-1:0]   cell_data;
    logic                scrolled;
  } console_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [ACTION_W-1:0]   in_tuser = ACT_PUT;

  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Shadow copy of the console: screen words, cursor and attribute.
  logic [CELL_W-1:0] screen_words [0:CELL_COUNT-1];
  logic [6:0]        cursor_col;
  logic [4:0]        cursor_row;
  logic [ATTR_W-1:0] attr_shadow;

  // Predicted cursor reports, oldest first.
  console_result_t pending_reports [$];

  int  mismatch_count = 0;
  int  stalled_cycles = 0;
  bit  source_idles = 1'b1;
  bit  sink_idles = 1'b1;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  int  stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_console_writer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // char_code[7:0], cell_address[18:8]
    .in_tuser    (in_tuser),    // action[1:0]
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // cursor_position[10:0], cell_data[26:11], scrolled[27]
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // Console predictor
  // ---------------------------------------------------------------------------

  // Fill the shadow screen with blanks in the current attribute.
  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_words[i] = {attr_shadow, CH_SPACE};
    end
  endfunction

  function automatic void reset_shadow();
    attr_shadow = ATTR_RESET;
    blank_screen();
    cursor_col = '0;
    cursor_row = '0;
  endfunction

  // Move every row up by one and blank the bottom row once the cursor has
  // dropped below the last row.
  function automatic logic scroll_if_past_bottom();
    if (cursor_row < ROWS) begin
      return 1'b0;
    end
    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
      screen_words[i] = screen_words[i + COLUMNS];
    end
    for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
      screen_words[i] = {attr_shadow, CH_SPACE};
    end
    cursor_row = 5'(ROWS - 1);
    return 1'b1;
  endfunction

  function automatic logic put_char(input logic [CHAR_W-1:0] code);
    case (code)
      CH_BS: begin
        // Backspace stops at the left edge.
        if (cursor_col != 0) begin
          cursor_col = cursor_col - 1'b1;
        end
      end
      CH_TAB: cursor_col = 7'(cursor_col + TAB_WIDTH - (cursor_col % TAB_WIDTH));
      CH_CR:  cursor_col = '0;
      CH_LF: begin
        cursor_col = '0;
        cursor_row = cursor_row + 1'b1;
      end
      default: begin
        // Only 0x20..0x7F print; high bytes count as negative chars and drop out.
        if (code >= CH_SPACE && code <= CH_DEL) begin
          screen_words[cursor_row * COLUMNS + cursor_col] = {attr_shadow, code};
          cursor_col = cursor_col + 1'b1;
        end
      end
    endcase
    if (cursor_col >= COLUMNS) begin
      cursor_col = '0;
      cursor_row = cursor_row + 1'b1;
    end
    return scroll_if_past_bottom();
  endfunction

  // Apply one request to the shadow console and return the report it gives.
  function automatic console_result_t predict_console_step(
    input logic [ACTION_W-1:0] action,
    input logic [CHAR_W-1:0]   code,
    input logic [ADDR_W-1:0]   addr
  );
    console_result_t report;
    report.cell_data = '0;
    report.scrolled  = 1'b0;
    case (action)
      ACT_PUT: report.scrolled = put_char(code);
      ACT_CLEAR: begin
        blank_screen();
        cursor_col = '0;
        cursor_row = '0;
      end
      ACT_READ: begin
        // Addresses past the screen read as zero.
        if (addr < CELL_COUNT) begin
          report.cell_data = screen_words[addr];
        end
      end
      default: begin
        // Unused action: report the cursor only.
      end
    endcase
    report.cursor_pos = CURSOR_W'(cursor_row * COLUMNS + cursor_col);
    return report;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on every accepted request, check every accepted report
  // ---------------------------------------------------------------------------

  task automatic check_field(input string field, input logic [CELL_W-1:0] want,
                             input logic [CELL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    console_result_t want;
    console_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.cursor_pos = out_tdata[OUT_CUR_LSB +: CURSOR_W];
        got.cell_data  = out_tdata[OUT_CELL_LSB +: CELL_W];
        got.scrolled   = out_tdata[OUT_SCR_BIT];
        if (pending_reports.size() == 0) begin
          $error("report with no request pending: cursor_position 0x%0h", got.cursor_pos);
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("cursor_position", CELL_W'(want.cursor_pos), CELL_W'(got.cursor_pos));
          check_field("cell_data", want.cell_data, got.cell_data);
          check_field("scrolled", CELL_W'(want.scrolled), CELL_W'(got.scrolled));
        end
      end
      if (in_tvalid && in_tready) begin
        pending_reports.push_back(predict_console_step(in_tuser,
                                                       in_tdata[IN_CHAR_LSB +: CHAR_W],
                                                       in_tdata[IN_ADDR_LSB +: ADDR_W]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stall bursts plus an on-demand long hold-off
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      // Start a long hold-off so the block fills up and stalls its input.
      hold_served <= hold_requests;
      hold_left   <= HOLD_OFF_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (sink_idles && $urandom_range(0, 99) < 20) begin
      // Start a stall burst, this cycle included; stall_left holds the rest.
      stall_left <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves for too long
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver and config writer (all called at a rising edge)
  // ---------------------------------------------------------------------------

  // Offer one request, optionally after a random idle burst, and return at the
  // edge where it is accepted. Valid stays high so back-to-back requests never
  // drop it within one time step.
  task automatic send_request(input logic [ACTION_W-1:0] action,
                              input logic [CHAR_W-1:0]   code,
                              input logic [ADDR_W-1:0]   addr);
    int gap;
    gap = 0;
    if (source_idles && $urandom_range(0, 99) < 25) begin
      gap = $urandom_range(1, 14);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= action;
    in_tdata  <= (IN_DATA_W'(addr) << IN_ADDR_LSB) | (IN_DATA_W'(code) << IN_CHAR_LSB);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and hold until every predicted report has come back. Step to the
  // next edge first so the request accepted at this edge is already queued.
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup then access phase; the register takes the value at the access edge.
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ATTR_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    attr_shadow = value;
  endtask

  // Mostly text and line control so the cursor wraps and scrolls often; the
  // rest is reads, stray bytes, unused actions and the odd clear.
  task automatic send_random_request();
    int                  pick;
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   code;
    logic [ADDR_W-1:0]   addr;
    pick   = $urandom_range(0, 99);
    action = ACT_PUT;
    code   = CHAR_W'($urandom_range(0, 255));
    addr   = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
    if (pick < 55) begin
      code = CHAR_W'($urandom_range(CH_SPACE, CH_DEL));
    end else if (pick < 67) begin
      code = CH_LF;
    end else if (pick < 72) begin
      code = CH_CR;
    end else if (pick < 77) begin
      code = CH_TAB;
    end else if (pick < 82) begin
      code = CH_BS;
    end else if (pick < 87) begin
      // Keep the fully random byte: control codes and high bytes alike.
    end else if (pick < 97) begin
      action = ACT_READ;
    end else if (pick < 99) begin
      action = ACT_NONE;
    end else begin
      action = ACT_CLEAR;
    end
    send_request(action, code, addr);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Screen right after the clearing pass, reads past the end, unused action.
  task automatic test_reset_contents();
    send_request(ACT_READ, CH_NUL, '0);
    send_request(ACT_READ, CH_HIGH_TOP, ADDR_W'(CELL_COUNT - 1));
    send_request(ACT_READ, CH_NUL, ADDR_W'(CELL_COUNT));
    send_request(ACT_READ, CH_HIGH_TOP, '1);
    send_request(ACT_NONE, CH_UPPER_A, '1);
  endtask

  // Printable edges, ignored bytes, and every cursor control.
  task automatic test_control_codes();
    send_request(ACT_PUT, CH_UPPER_A, '0);
    send_request(ACT_PUT, CH_DEL, '1);
    send_request(ACT_PUT, CH_HIGH_LOW, '0);
    send_request(ACT_PUT, CH_HIGH_TOP, '0);
    send_request(ACT_PUT, CH_NUL, '0);
    send_request(ACT_PUT, CH_ESC, '0);
    send_request(ACT_PUT, CH_SPACE, '0);
    send_request(ACT_PUT, CH_BS, '0);
    send_request(ACT_PUT, CH_TAB, '0);
    send_request(ACT_PUT, CH_CR, '0);
    // Backspace at the left edge must leave the cursor where it is.
    send_request(ACT_PUT, CH_BS, '0);
    send_request(ACT_PUT, CH_LF, '0);
    send_request(ACT_READ, CH_NUL, ADDR_W'(0));
    send_request(ACT_READ, CH_NUL, ADDR_W'(1));
  endtask

  // Attribute extremes: new writes and blanks pick it up, old words keep theirs.
  task automatic test_attribute_extremes();
    pause_until_drained();
    write_attribute(ATTR_ALL_ZERO);
    send_request(ACT_PUT, CH_LOWER_X, '0);
    send_request(ACT_READ, CH_NUL, ADDR_W'(COLUMNS));
    send_request(ACT_CLEAR, CH_NUL, '0);
    send_request(ACT_READ, CH_NUL, ADDR_W'(0));
    pause_until_drained();
    write_attribute(ATTR_ALL_ONE);
    send_request(ACT_PUT, CH_UPPER_Z, '0);
    send_request(ACT_READ, CH_NUL, ADDR_W'(0));
    send_request(ACT_READ, CH_NUL, ADDR_W'(1));
  endtask

  // Hold the receiver off while the sender keeps offering text.
  task automatic test_backpressure();
    source_idles = 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (12) send_random_request();
    source_idles = 1'b1;
  endtask

  // Random text in chunks, each with its own attribute; the last chunk runs
  // with no idling on either side and restores the reset attribute.
  task automatic test_random_text();
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      pause_until_drained();
      source_idles = (chunk != RANDOM_CHUNKS - 1);
      sink_idles  <= (chunk != RANDOM_CHUNKS - 1);
      if (chunk == RANDOM_CHUNKS - 1) begin
        write_attribute(ATTR_RESET);
      end else begin
        write_attribute(ATTR_W'($urandom_range(0, 255)));
      end
      repeat (CHUNK_REQUESTS) send_random_request();
    end
  endtask

  initial begin
    reset_shadow();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Hold off until the post-reset clearing pass has finished.
    do @(posedge clk); while (!in_tready);

    test_reset_contents();
    test_control_codes();
    test_attribute_extremes();
    test_backpressure();
    test_random_text();

    // Drain, then give any stray report time to show up.
    pause_until_drained();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
